// File: rtl/coincidence_event_builder_core_defines.svh
// ----------------------------------------------------------------------------
// Coincidence event builder assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef COINCIDENCE_EVENT_BUILDER_CORE_DEFINES_SVH
`define COINCIDENCE_EVENT_BUILDER_CORE_DEFINES_SVH

// Same-cycle implication.
`define CEB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("event builder assertion failed");

// Next-cycle implication.
`define CEB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("event builder assertion failed");

`endif

// File: rtl/ceb_pkg.sv
// ----------------------------------------------------------------------------
// Coincidence event builder package
// Sizes, register indexes, reset values and the queue item type.
// ----------------------------------------------------------------------------
`default_nettype none

package ceb_pkg;

    localparam int NUM_POS_CHANNELS = 4;
    localparam int TIME_BITS        = 48;
    localparam int COUNT_BITS       = 32;

    localparam int CH_BITS        = 3;
    localparam int PULSE_BITS     = 13;
    localparam int WIN_BITS       = 16;
    localparam int HIT_BITS       = 8;
    localparam int TOTAL_BITS     = 10;
    localparam int OUT_PULSES     = 4;
    localparam int OUT_COUNT_BITS = 32;
    localparam int SUM_BITS       = HIT_BITS + 4;
    localparam int POS_IDX_BITS   = (NUM_POS_CHANNELS > 1) ? $clog2(NUM_POS_CHANNELS) : 1;

    localparam logic [HIT_BITS-1:0]   HIT_SAT   = '1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_SAT = '1;

    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_KICKER_CH = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AUX_CH    = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW    = 4'd3;

    localparam logic [CH_BITS-1:0]    KICKER_CH_RST = 3'd5;
    localparam logic [CH_BITS-1:0]    AUX_CH_RST    = 3'd4;
    localparam logic [PULSE_BITS-1:0] THRESHOLD_RST = 13'd512;
    localparam logic [WIN_BITS-1:0]   WINDOW_RST    = 16'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                    flush;
        logic                    kick_hit;
        logic                    aux_hit;
        logic                    pos_hit;
        logic [POS_IDX_BITS-1:0] pos_idx;
        logic [PULSE_BITS-1:0]   pulse;
        logic [TIME_BITS-1:0]    stamp;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_push;

endpackage

`default_nettype wire

// File: rtl/ceb_front.sv
// ----------------------------------------------------------------------------
// Coincidence event builder front end
// Holds the configuration registers, accepts input beats and classifies them.
// ----------------------------------------------------------------------------
`default_nettype none

module ceb_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [ceb_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [ceb_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic                               i_req_type,
    input  wire logic [ceb_pkg::CH_BITS-1:0]        i_channel,
    input  wire logic [ceb_pkg::PULSE_BITS-1:0]     i_pulse_height,
    input  wire logic [ceb_pkg::TIME_BITS-1:0]      i_timestamp,
    input  wire logic                               i_q_ready,
    output ceb_pkg::t_push                          o_push,
    output logic [ceb_pkg::WIN_BITS-1:0]            o_window_ticks
);

    logic [ceb_pkg::CH_BITS-1:0]    r_kicker_ch, n_kicker_ch;
    logic [ceb_pkg::CH_BITS-1:0]    r_aux_ch, n_aux_ch;
    logic [ceb_pkg::PULSE_BITS-1:0] r_thresh, n_thresh;
    logic [ceb_pkg::WIN_BITS-1:0]   r_window, n_window;

    logic above;
    logic kick;

    always_comb begin
        n_kicker_ch = r_kicker_ch;
        n_aux_ch    = r_aux_ch;
        n_thresh    = r_thresh;
        n_window    = r_window;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ceb_pkg::CFG_KICKER_CH: n_kicker_ch = i_cfg_data[ceb_pkg::CH_BITS-1:0];
                ceb_pkg::CFG_AUX_CH:    n_aux_ch    = i_cfg_data[ceb_pkg::CH_BITS-1:0];
                ceb_pkg::CFG_THRESHOLD: n_thresh    = i_cfg_data[ceb_pkg::PULSE_BITS-1:0];
                ceb_pkg::CFG_WINDOW:    n_window    = i_cfg_data[ceb_pkg::WIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kicker_ch <= ceb_pkg::KICKER_CH_RST;
            r_aux_ch    <= ceb_pkg::AUX_CH_RST;
            r_thresh    <= ceb_pkg::THRESHOLD_RST;
            r_window    <= ceb_pkg::WINDOW_RST;
        end else begin
            r_kicker_ch <= n_kicker_ch;
            r_aux_ch    <= n_aux_ch;
            r_thresh    <= n_thresh;
            r_window    <= n_window;
        end
    end

    // A pulse on the kicker channel never also counts as auxiliary.
    assign above = i_pulse_height > r_thresh;
    assign kick  = (i_channel == r_kicker_ch) && above;

    always_comb begin
        o_push.valid         = i_valid && i_q_ready;
        o_push.item.flush    = i_req_type;
        o_push.item.kick_hit = kick;
        o_push.item.aux_hit  = !kick && (i_channel == r_aux_ch) && above;
        o_push.item.pos_hit  = {1'b0, i_channel} <
                               (ceb_pkg::CH_BITS + 1)'(ceb_pkg::NUM_POS_CHANNELS);
        o_push.item.pos_idx  = ceb_pkg::POS_IDX_BITS'(i_channel);
        o_push.item.pulse    = i_pulse_height;
        o_push.item.stamp    = i_timestamp;
    end

    assign o_ready        = i_q_ready;
    assign o_cfg_ready    = 1'b1;
    assign o_window_ticks = r_window;

endmodule

`default_nettype wire

// File: rtl/ceb_queue.sv
// ----------------------------------------------------------------------------
// Coincidence event builder queue
// Short FIFO of classified beats between the front end and the event logic.
// ----------------------------------------------------------------------------
`default_nettype none

module ceb_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ceb_pkg::t_push i_push,
    output logic                o_ready,
    output logic                o_valid,
    output ceb_pkg::t_item      o_item,
    input  wire logic           i_pop
);

    ceb_pkg::t_item                r_mem [ceb_pkg::QUEUE_DEPTH];
    logic [ceb_pkg::QPTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [ceb_pkg::QPTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [ceb_pkg::QCNT_BITS-1:0] r_count, n_count;

    logic push;
    logic pop;

    assign o_ready = r_count != ceb_pkg::QCNT_BITS'(ceb_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_push.valid;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == ceb_pkg::QPTR_BITS'(ceb_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == ceb_pkg::QPTR_BITS'(ceb_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ceb_back.sv
// ----------------------------------------------------------------------------
// Coincidence event builder back end
// Keeps the event state, decides window closure and registers each event.
// ----------------------------------------------------------------------------
`default_nettype none

module ceb_back (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [ceb_pkg::WIN_BITS-1:0]        i_window_ticks,
    input  wire logic                                i_q_valid,
    input  wire ceb_pkg::t_item                      i_item,
    output logic                                     o_pop,
    input  wire logic                                i_ready,
    output logic                                     o_valid,
    output logic [ceb_pkg::PULSE_BITS-1:0]           o_pulse [ceb_pkg::OUT_PULSES],
    output logic [ceb_pkg::TIME_BITS-1:0]            o_event_start,
    output logic [ceb_pkg::TIME_BITS-1:0]            o_flight_time,
    output logic [ceb_pkg::TOTAL_BITS-1:0]           o_hit_total,
    output logic [ceb_pkg::OUT_COUNT_BITS-1:0]       o_kicker_total,
    output logic [ceb_pkg::OUT_COUNT_BITS-1:0]       o_aux_total
);

    localparam int NPOS = ceb_pkg::NUM_POS_CHANNELS;
    localparam int TB   = ceb_pkg::TIME_BITS;

    logic [TB-1:0]                  r_ws, n_ws;
    logic [TB-1:0]                  r_tz, n_tz;
    logic [TB-1:0]                  r_flight, n_flight;
    logic [ceb_pkg::PULSE_BITS-1:0] r_pulse [NPOS];
    logic [ceb_pkg::PULSE_BITS-1:0] n_pulse [NPOS];
    logic [ceb_pkg::HIT_BITS-1:0]   r_hits [NPOS];
    logic [ceb_pkg::HIT_BITS-1:0]   n_hits [NPOS];
    logic [ceb_pkg::COUNT_BITS-1:0] r_kc, n_kc;
    logic [ceb_pkg::COUNT_BITS-1:0] r_ac, n_ac;
    logic                           r_kp, n_kp;
    logic                           r_ap, n_ap;
    logic                           r_out_valid, n_out_valid;

    logic [ceb_pkg::PULSE_BITS-1:0]     r_out_pulse [ceb_pkg::OUT_PULSES];
    logic [ceb_pkg::PULSE_BITS-1:0]     ev_pulse [ceb_pkg::OUT_PULSES];
    logic [TB-1:0]                      r_out_start;
    logic [TB-1:0]                      r_out_flight;
    logic [ceb_pkg::TOTAL_BITS-1:0]     r_out_total;
    logic [ceb_pkg::OUT_COUNT_BITS-1:0] r_out_kc;
    logic [ceb_pkg::OUT_COUNT_BITS-1:0] r_out_ac;

    logic                           advance;
    logic                           pop;
    logic                           kp;
    logic                           ap;
    logic                           active;
    logic                           borrow;
    logic [TB-1:0]                  diff;
    logic                           late;
    logic                           close;
    logic                           emit;
    logic [ceb_pkg::SUM_BITS-1:0]   sum;
    logic [ceb_pkg::TOTAL_BITS-1:0] total;

    assign advance = !r_out_valid || i_ready;
    assign pop     = i_q_valid && advance;
    assign o_pop   = pop;

    assign kp     = r_kp || i_item.kick_hit;
    assign ap     = r_ap || i_item.aux_hit;
    assign active = (r_kc != '0) || kp;

    // A stamp earlier than the window start never runs past the window.
    assign {borrow, diff} = {1'b0, i_item.stamp} - {1'b0, r_ws};
    assign late  = !borrow &&
                   (diff > {{(TB - ceb_pkg::WIN_BITS){1'b0}}, i_window_ticks});
    assign close = active && (late || kp || ap);
    assign emit  = pop && (i_item.flush || close);

    always_comb begin
        sum = '0;
        for (int i = 0; i < NPOS; i++) begin
            sum = sum + ceb_pkg::SUM_BITS'(r_hits[i]);
        end
        total = (sum > ceb_pkg::SUM_BITS'(ceb_pkg::TOTAL_SAT)) ?
                ceb_pkg::TOTAL_SAT : ceb_pkg::TOTAL_BITS'(sum);
    end

    for (genvar g = 0; g < ceb_pkg::OUT_PULSES; g++) begin : g_ev_pulse
        if (g < NPOS) begin : g_used
            assign ev_pulse[g] = r_pulse[g];
        end else begin : g_unused
            assign ev_pulse[g] = '0;
        end
    end

    always_comb begin
        n_ws     = r_ws;
        n_tz     = r_tz;
        n_flight = r_flight;
        n_pulse  = r_pulse;
        n_hits   = r_hits;
        n_kc     = r_kc;
        n_ac     = r_ac;
        n_kp     = r_kp;
        n_ap     = r_ap;
        if (pop) begin
            if (i_item.flush) begin
                for (int i = 0; i < NPOS; i++) begin
                    n_pulse[i] = '0;
                    n_hits[i]  = '0;
                end
            end else begin
                n_kp = kp;
                n_ap = ap;
                if (close) begin
                    if (kp) begin
                        n_kc     = (r_kc == '1) ? r_kc : r_kc + 1'b1;
                        n_tz     = i_item.stamp;
                        n_kp     = 1'b0;
                        n_flight = '0;
                    end else begin
                        n_flight = i_item.stamp - r_tz;
                    end
                    if (ap) begin
                        n_ac = (r_ac == '1) ? r_ac : r_ac + 1'b1;
                        n_ap = 1'b0;
                    end
                    for (int i = 0; i < NPOS; i++) begin
                        n_pulse[i] = '0;
                        n_hits[i]  = '0;
                    end
                    n_ws = i_item.stamp;
                end
                // Fill the event only once the first kicker has been seen.
                if (active && i_item.pos_hit) begin
                    n_pulse[i_item.pos_idx] = i_item.pulse;
                    n_hits[i_item.pos_idx]  =
                        (n_hits[i_item.pos_idx] == ceb_pkg::HIT_SAT) ?
                        ceb_pkg::HIT_SAT : n_hits[i_item.pos_idx] + 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws        <= '0;
            r_tz        <= '0;
            r_flight    <= '0;
            r_kc        <= '0;
            r_ac        <= '0;
            r_kp        <= 1'b0;
            r_ap        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NPOS; i++) begin
                r_pulse[i] <= '0;
                r_hits[i]  <= '0;
            end
        end else begin
            r_ws        <= n_ws;
            r_tz        <= n_tz;
            r_flight    <= n_flight;
            r_kc        <= n_kc;
            r_ac        <= n_ac;
            r_kp        <= n_kp;
            r_ap        <= n_ap;
            r_out_valid <= n_out_valid;
            r_pulse     <= n_pulse;
            r_hits      <= n_hits;
        end
    end

    // Capture the closing event from the state as it stood before this beat.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_pulse  <= ev_pulse;
            r_out_start  <= r_ws;
            r_out_flight <= r_flight;
            r_out_total  <= total;
            r_out_kc     <= ceb_pkg::OUT_COUNT_BITS'(r_kc);
            r_out_ac     <= ceb_pkg::OUT_COUNT_BITS'(r_ac);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pulse        = r_out_pulse;
    assign o_event_start  = r_out_start;
    assign o_flight_time  = r_out_flight;
    assign o_hit_total    = r_out_total;
    assign o_kicker_total = r_out_kc;
    assign o_aux_total    = r_out_ac;

endmodule

`default_nettype wire

// File: rtl/coincidence_event_builder_core.sv
// ----------------------------------------------------------------------------
// Coincidence event builder core
// Groups timestamped position hits into events ended by kicker, aux, timeout or flush.
// ----------------------------------------------------------------------------
// One input beat is taken every clock cycle while the output side keeps up.
// The input beat that closes an event is written into the queue on the edge
// that accepts it. The event register loads when that beat is popped, and
// drives the output from then on. The event logic sets the rate and updates
// the window, counts and held pulses for one beat per cycle unless stalled,
// around a single 48-bit window subtract and compare. A two-entry queue sits
// between input classification and the event logic. While a finished event
// waits on a stalled output, the input side keeps taking beats until the
// queue is full. Configuration writes are always taken at once and should
// only be issued while the block is idle. No clearing pass after reset.
`default_nettype none

module coincidence_event_builder_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [ceb_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  wire logic [ceb_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic                                  i_req_type,
    input  wire logic [ceb_pkg::CH_BITS-1:0]           i_channel,
    input  wire logic [ceb_pkg::PULSE_BITS-1:0]        i_pulse_height,
    input  wire logic [ceb_pkg::TIME_BITS-1:0]         i_timestamp,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic [ceb_pkg::PULSE_BITS-1:0]             o_pulse_ch0,
    output logic [ceb_pkg::PULSE_BITS-1:0]             o_pulse_ch1,
    output logic [ceb_pkg::PULSE_BITS-1:0]             o_pulse_ch2,
    output logic [ceb_pkg::PULSE_BITS-1:0]             o_pulse_ch3,
    output logic [ceb_pkg::TIME_BITS-1:0]              o_event_start,
    output logic [ceb_pkg::TIME_BITS-1:0]              o_flight_time,
    output logic [ceb_pkg::TOTAL_BITS-1:0]             o_hit_total,
    output logic [ceb_pkg::OUT_COUNT_BITS-1:0]         o_kicker_total,
    output logic [ceb_pkg::OUT_COUNT_BITS-1:0]         o_aux_total
);

    ceb_pkg::t_push                 push;
    ceb_pkg::t_item                 q_item;
    logic                           q_ready;
    logic                           q_valid;
    logic                           q_pop;
    logic [ceb_pkg::WIN_BITS-1:0]   window_ticks;
    logic [ceb_pkg::PULSE_BITS-1:0] pulse [ceb_pkg::OUT_PULSES];

    ceb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_channel      (i_channel),
        .i_pulse_height (i_pulse_height),
        .i_timestamp    (i_timestamp),
        .i_q_ready      (q_ready),
        .o_push         (push),
        .o_window_ticks (window_ticks)
    );

    ceb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    ceb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_window_ticks (window_ticks),
        .i_q_valid      (q_valid),
        .i_item         (q_item),
        .o_pop          (q_pop),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_pulse        (pulse),
        .o_event_start  (o_event_start),
        .o_flight_time  (o_flight_time),
        .o_hit_total    (o_hit_total),
        .o_kicker_total (o_kicker_total),
        .o_aux_total    (o_aux_total)
    );

    assign o_pulse_ch0 = pulse[0];
    assign o_pulse_ch1 = pulse[1];
    assign o_pulse_ch2 = pulse[2];
    assign o_pulse_ch3 = pulse[3];

endmodule

`default_nettype wire

// File: rtl/ceb_checker.sv
// ----------------------------------------------------------------------------
// Coincidence event builder checker
// Port-level assertions on event beats, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "coincidence_event_builder_core_defines.svh"

module ceb_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                o_valid,
    input wire logic                                i_ready,
    input wire logic [ceb_pkg::TIME_BITS-1:0]       o_event_start,
    input wire logic [ceb_pkg::TIME_BITS-1:0]       o_flight_time,
    input wire logic [ceb_pkg::TOTAL_BITS-1:0]      o_hit_total,
    input wire logic [ceb_pkg::OUT_COUNT_BITS-1:0]  o_kicker_total,
    input wire logic [ceb_pkg::OUT_COUNT_BITS-1:0]  o_aux_total
);

    logic                                r_seen;
    logic [ceb_pkg::OUT_COUNT_BITS-1:0]  r_last_kc;
    logic [ceb_pkg::OUT_COUNT_BITS-1:0]  r_last_ac;
    logic                                out_beat;

    assign out_beat = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= 1'b0;
            r_last_kc <= '0;
            r_last_ac <= '0;
        end else if (out_beat) begin
            r_seen    <= 1'b1;
            r_last_kc <= o_kicker_total;
            r_last_ac <= o_aux_total;
        end
    end

    // Hold a stalled event beat.
    `CEB_ASSERT_NXT(a_out_hold, o_valid && !i_ready,
        o_valid && $stable(o_event_start) && $stable(o_flight_time) && $stable(o_hit_total))

    // Counts only ever advance or saturate between events.
    `CEB_ASSERT_IMP(a_kicker_mono, out_beat && r_seen, o_kicker_total >= r_last_kc)
    `CEB_ASSERT_IMP(a_aux_mono, out_beat && r_seen, o_aux_total >= r_last_ac)

    // Per-channel counts saturate, so the total stays within their sum.
    `CEB_ASSERT_IMP(a_hit_bound, o_valid,
        32'(o_hit_total) <= ceb_pkg::NUM_POS_CHANNELS * 32'(ceb_pkg::HIT_SAT))

endmodule

bind coincidence_event_builder_core ceb_checker u_ceb_checker (.*);

`default_nettype wire
